// ----- hdl/sha_pkg.sv -----
// Shared types, command struct, round constants and initial hash values for the SHA-256 hasher.
package sha_pkg;

  typedef enum logic [1:0] {
    SRC_IN   = 2'd0,
    SRC_MARK = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      shift_en;
    byte_src_t src;
    logic [2:0] len_idx;
    logic      count_en;
    logic      load_v;
    logic      round_en;
    logic [5:0] round;
    logic      add_chain;
    logic      init;
    logic [1:0] part;
  } dp_cmd_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [1:0] PART_LAST = 2'd3;

  localparam logic [31:0] H_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/sha_ctrl.sv -----
// Controller state machine: byte intake, padding, round sequencing and digest output.
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tuser,
  input  logic       in_tlast,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_tuser,
  output logic       out_tlast,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_ACC  = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [1:0] part_r, part_nxt;
  logic       pad_r, pad_nxt;
  logic       first_r, first_nxt;
  logic       len_ok_r, len_ok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_ACC;
      fill_r   <= '0;
      rnd_r    <= '0;
      part_r   <= '0;
      pad_r    <= 1'b0;
      first_r  <= 1'b0;
      len_ok_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rnd_r    <= rnd_nxt;
      part_r   <= part_nxt;
      pad_r    <= pad_nxt;
      first_r  <= first_nxt;
      len_ok_r <= len_ok_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    rnd_nxt      = rnd_r;
    part_nxt     = part_r;
    pad_nxt      = pad_r;
    first_nxt    = first_r;
    len_ok_nxt   = len_ok_r;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    cmd          = '0;
    cmd.src      = SRC_IN;
    cmd.len_idx  = fill_r[2:0];
    cmd.round    = rnd_r;
    cmd.part     = part_r;
    case (state_r)
      ST_ACC: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.shift_en = 1'b1;
            cmd.count_en = 1'b1;
            fill_nxt     = fill_r + 6'd1;
          end
          if (in_tlast) begin
            pad_nxt   = 1'b1;
            first_nxt = 1'b1;
          end
          if (in_tuser && fill_r == BLOCK_LAST) begin
            cmd.load_v = 1'b1;
            rnd_nxt    = '0;
            state_nxt  = ST_COMP;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_en = 1'b1;
        if (first_r) begin
          cmd.src = SRC_MARK;
        end else if (fill_r >= LEN_START && len_ok_r) begin
          cmd.src = SRC_LEN;
        end else begin
          cmd.src = SRC_ZERO;
        end
        first_nxt = 1'b0;
        if (first_r && fill_r < LEN_START) begin
          len_ok_nxt = 1'b1;
        end
        fill_nxt = fill_r + 6'd1;
        if (fill_r == BLOCK_LAST) begin
          cmd.load_v = 1'b1;
          rnd_nxt    = '0;
          state_nxt  = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.add_chain = 1'b1;
        if (pad_r && len_ok_r) begin
          part_nxt  = '0;
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          len_ok_nxt = 1'b1;
          state_nxt  = ST_PAD;
        end else begin
          state_nxt = ST_ACC;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          part_nxt = part_r + 2'd1;
          if (part_r == PART_LAST) begin
            cmd.init   = 1'b1;
            pad_nxt    = 1'b0;
            first_nxt  = 1'b0;
            len_ok_nxt = 1'b0;
            fill_nxt   = '0;
            state_nxt  = ST_ACC;
          end
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  assign out_tuser = part_r;
  assign out_tlast = (part_r == PART_LAST);

endmodule

// ----- hdl/sha_dp.sv -----
// Datapath: block shift buffer and schedule window, round unit, chaining value and bit counter.
module sha_dp
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_byte,
  output logic [63:0] digest_part
);

  logic [511:0] blk_r;
  logic [31:0]  v_r [0:7];
  logic [31:0]  chain_r [0:7];
  logic [63:0]  bits_r;

  logic [7:0]  byte_in;
  logic [31:0] w0, w1, w9, w14, w_new, s0, s1;
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] t1, t2, big_s0, big_s1, ch, maj;

  always_comb begin
    case (cmd.src)
      SRC_IN:   byte_in = in_byte;
      SRC_MARK: byte_in = PAD_MARK;
      SRC_LEN:  byte_in = bits_r[{~cmd.len_idx, 3'b000} +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
  assign s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
  assign w_new = w0 + s0 + w9 + s1;

  assign a = v_r[0];
  assign b = v_r[1];
  assign c = v_r[2];
  assign d = v_r[3];
  assign e = v_r[4];
  assign f = v_r[5];
  assign g = v_r[6];
  assign h = v_r[7];
  assign big_s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign big_s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign ch  = (e & f) ^ (~e & g);
  assign maj = (a & b) ^ (a & c) ^ (b & c);
  assign t1  = h + big_s1 + ch + round_k(cmd.round) + w0;
  assign t2  = big_s0 + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk_r <= {blk_r[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_v) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= a;
      v_r[2] <= b;
      v_r[3] <= c;
      v_r[4] <= d + t1;
      v_r[5] <= e;
      v_r[6] <= f;
      v_r[7] <= g;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= H_INIT[i];
      end
      bits_r <= '0;
    end else begin
      if (cmd.add_chain) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + v_r[i];
        end
      end
      if (cmd.count_en) begin
        bits_r <= bits_r + 64'd8;
      end
    end
  end

  assign digest_part = {chain_r[{cmd.part, 1'b0}], chain_r[{cmd.part, 1'b1}]};

endmodule

// ----- hdl/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: controller and datapath joined by the command struct.
//
//   channel | direction | tdata            | tuser             | tlast
//   in_     | request   | [7:0] data_byte  | [0] byte_valid    | end_of_message
//   out_    | result    | [63:0] digest    | [1:0] part_number | last_part
//
// A message byte is taken every cycle while a block fills; the 64th byte of a block holds
// the input while the single round unit runs 64 rounds and the chaining value is updated.
// An end mark pads one byte per cycle to the block end, runs one or two compressions,
// then offers four digest parts, one per cycle while out_tready is high.
// Synchronous active-low reset loads the initial hash values and clears the counters.
// A stalled out_tready holds the current part and blocks further requests.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_part
  output logic [1:0]  out_tuser,  // [1:0] part_number
  output logic        out_tlast
);

  dp_cmd_t cmd;

  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .digest_part (out_tdata)
  );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the SHA-256 stream hasher: directed and random messages.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_REQUESTS = 90;
  localparam int MIN_MESSAGES = 12;
  localparam int BOUNDARY_LEN [4] = '{55, 56, 63, 64};

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE
  } idle_phase_t;

  typedef struct packed {
    logic [63:0] digest;
    logic [1:0]  part;
    logic        last;
  } digest_part_t;

  typedef struct packed {
    logic         byte_valid;
    logic [7:0]   data_byte;
    logic         end_mark;
    logic         typed;
    logic [255:0] digest;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [15] = '{
    '{1'b0, 8'h00, 1'b1, 1'b1, EMPTY_DIGEST},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'h61, 1'b0, 1'b0, '0},
    '{1'b1, 8'h62, 1'b0, 1'b0, '0},
    '{1'b1, 8'h63, 1'b1, 1'b1, ABC_DIGEST},
    '{1'b1, 8'h00, 1'b1, 1'b0, '0},
    '{1'b1, 8'hff, 1'b1, 1'b0, '0},
    '{1'b1, 8'h5a, 1'b0, 1'b0, '0},
    '{1'b0, 8'ha5, 1'b0, 1'b0, '0},
    '{1'b1, 8'ha5, 1'b0, 1'b0, '0},
    '{1'b1, 8'hff, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b1, 1'b0, '0},
    '{1'b0, 8'hff, 1'b1, 1'b1, EMPTY_DIGEST},
    '{1'b1, 8'h80, 1'b0, 1'b0, '0},
    '{1'b1, 8'h01, 1'b1, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] byte_valid
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;          // [63:0] digest_part
  logic [1:0]  out_tuser;          // [1:0] part_number
  logic        out_tlast;

  logic [31:0]  chain_h [8];
  logic [7:0]   msg_block [64];
  int           fill;
  logic [63:0]  bit_len;
  digest_part_t digest_q [$];

  int mismatches = 0;
  int requests_accepted = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  sha256_stream_hasher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_restart();
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_H0[i];
    fill = 0;
    bit_len = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic logic sha_absorb(input logic byte_valid, input logic [7:0] data_byte,
                                      input logic end_mark, output logic [255:0] digest);
    digest = '0;
    if (byte_valid) begin
      msg_block[fill] = data_byte;
      fill++;
      bit_len += 64'd8;
      if (fill == 64) begin
        sha_compress();
        fill = 0;
      end
    end
    if (!end_mark) return 1'b0;
    msg_block[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin
        msg_block[fill] = 8'h00;
        fill++;
      end
      sha_compress();
      fill = 0;
    end
    while (fill < 56) begin
      msg_block[fill] = 8'h00;
      fill++;
    end
    for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
    sha_compress();
    digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
              chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    sha_restart();
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic offer(input logic byte_valid, input logic [7:0] data_byte,
                       input logic end_mark, input logic typed, input logic [255:0] typed_digest);
    logic [255:0] digest;
    digest_part_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data_byte;
    in_tuser <= byte_valid;
    in_tlast <= end_mark;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (byte_valid || end_mark) requests_accepted++;
    if (sha_absorb(byte_valid, data_byte, end_mark, digest)) begin
      if (typed) digest = typed_digest;
      for (int k = 0; k < 4; k++) begin
        want.digest = digest[255 - 64*k -: 64];
        want.part = 2'(k);
        want.last = (k == 3);
        digest_q.push_back(want);
      end
    end
  endtask

  task automatic send_message(input int len, input bit hold_at_end);
    logic end_with_byte;
    end_with_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) offer(1'b0, 8'($urandom_range(255)), 1'b0, 1'b0, '0);
      if (hold_at_end && end_with_byte && i == len - 1) hold_gen++;
      offer(1'b1, 8'($urandom_range(255)), end_with_byte && i == len - 1, 1'b0, '0);
    end
    if (!end_with_byte) begin
      if (hold_at_end) hold_gen++;
      offer(1'b0, 8'($urandom_range(255)), 1'b1, 1'b0, '0);
    end
  endtask

  task automatic drain_digests();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // hold off for a long stretch on request, else stall at the phase rate
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    digest_part_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        note_mismatch($sformatf("unexpected digest part %0d", out_tuser));
      end else begin
        want = digest_q.pop_front();
        if (out_tdata !== want.digest)
          note_mismatch($sformatf("part %0d digest %h, want %h",
                                  want.part, out_tdata, want.digest));
        if (out_tuser !== want.part)
          note_mismatch($sformatf("part number %0d, want %0d", out_tuser, want.part));
        if (out_tlast !== want.last)
          note_mismatch($sformatf("part %0d last %b, want %b", want.part, out_tlast, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    idle_phase_t phase;
    int msg_count;
    int len;
    sha_restart();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < $size(DIRECTED_ROWS); r++)
      offer(DIRECTED_ROWS[r].byte_valid, DIRECTED_ROWS[r].data_byte, DIRECTED_ROWS[r].end_mark,
            DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].digest);

    requests_accepted = 0;
    msg_count = 0;
    while (requests_accepted < RANDOM_REQUESTS || msg_count < MIN_MESSAGES) begin
      if (msg_count % 3 == 0) begin
        drain_digests();
        phase = idle_phase_t'((msg_count / 3) % 4);
        case (phase)
          PH_STEADY: begin
            idle_pct = 0;
            stall_pct = 0;
          end
          PH_SENDER_IDLE: begin
            idle_pct = 68;
            stall_pct = 0;
          end
          PH_RECEIVER_STALL: begin
            idle_pct = 0;
            stall_pct = 68;
          end
          default: begin
            idle_pct = 18;
            stall_pct = 18;
          end
        endcase
      end
      if (msg_count == 0) len = BOUNDARY_LEN[$urandom_range(3)];
      else len = $urandom_range(4);
      send_message(len, msg_count == 1 || msg_count == 7);
      msg_count++;
    end

    // leave a partial message behind with no end mark
    offer(1'b0, 8'($urandom_range(255)), 1'b0, 1'b0, '0);
    for (int i = 0; i < 3; i++) offer(1'b1, 8'($urandom_range(255)), 1'b0, 1'b0, '0);

    drain_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_q.size() != 0)
      note_mismatch($sformatf("%0d digest parts never arrived", digest_q.size()));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
